// ===== rtl/sliding_window_average_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window average core
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_AVERAGE_CORE_ASSERT_SVH
`define SLIDING_WINDOW_AVERAGE_CORE_ASSERT_SVH

// same-cycle implication
`define SWA_ASSERT_HOLDS(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("swa: same-cycle check failed");

// next-cycle implication
`define SWA_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("swa: next-cycle check failed");

`endif

// ===== rtl/swa_pkg.sv =====
// ----------------------------------------------------------------------------
// swa_pkg
// Widths, codes and defaults shared by the sliding window average core.
// ----------------------------------------------------------------------------
package swa_pkg;

   localparam int unsigned MAX_WINDOW_DEF  = 1024;
   localparam int unsigned SAMPLE_BITS_DEF = 32;

   localparam int unsigned MODE_W   = 2;
   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned SPAN_W   = 11;
   localparam int unsigned WLEN_W   = 11;
   localparam int unsigned AVG_W    = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned FILL_W   = 11;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam logic [WLEN_W-1:0] WLEN_RESET = 11'd60;

   localparam mode_type MODE_SAMPLE = 2'd0;
   localparam mode_type MODE_AWAIT  = 2'd1;
   localparam mode_type MODE_FAIL   = 2'd2;
   localparam mode_type MODE_QUERY  = 2'd3;

   localparam status_type ST_INITIAL = 2'd0;
   localparam status_type ST_AWAIT   = 2'd1;
   localparam status_type ST_ACTIVE  = 2'd2;
   localparam status_type ST_NOTSUP  = 2'd3;

endpackage

// ===== rtl/swa_if.sv =====
// ----------------------------------------------------------------------------
// swa request / response interfaces
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
interface swa_req_if import swa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   mode_type                   mode;
   logic signed [SAMPLE_W-1:0] sample;
   logic [SPAN_W-1:0]          span;

   modport source (output valid, output mode, output sample, output span, input ready);
   modport sink   (input valid, input mode, input sample, input span, output ready);
endinterface

interface swa_rsp_if import swa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [AVG_W-1:0] average;
   logic                    valid_res;
   status_type              status;
   logic [FILL_W-1:0]       fill;

   modport source (output valid, output average, output valid_res, output status,
                   output fill, input ready);
   modport sink   (input valid, input average, input valid_res, input status,
                   input fill, output ready);
endinterface

// ===== rtl/swa_sample_ram.sv =====
// ----------------------------------------------------------------------------
// swa_sample_ram
// Simple dual-port sample store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module swa_sample_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/swa_divider.sv =====
// ----------------------------------------------------------------------------
// swa_divider
// Bit-serial restoring divider, signed dividend by unsigned nonzero divisor,
// quotient truncated toward zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "sliding_window_average_core_assert.svh"

module swa_divider import swa_pkg::*; #(
   parameter int unsigned DVD_W = 42,
   parameter int unsigned DVS_W = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0]        divisor,
   output logic                    done,
   output logic signed [DVD_W-1:0] quotient
);

   localparam int unsigned STEP_W = $clog2(DVD_W);

   logic              busy_ff, busy_in;
   logic              fix_ff, fix_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  q_ff, q_in;

   logic [DVS_W:0]    rem_sh;
   logic [DVS_W:0]    trial;
   logic              ge;

   assign rem_sh = {rem_ff, q_ff[DVD_W-1]};
   assign ge     = rem_sh >= {1'b0, dvs_ff};
   assign trial  = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      fix_in  = fix_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         // work on the magnitude, fix the sign at the end
         neg_in  = dividend[DVD_W-1];
         q_in    = dividend[DVD_W-1] ? DVD_W'(-dividend) : dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         q_in    = {q_ff[DVD_W-2:0], ge};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         fix_in  = 1'b0;
         done_in = 1'b1;
         q_in    = neg_ff ? DVD_W'(-q_ff) : q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      neg_ff  <= neg_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

   `SWA_ASSERT_HOLDS(a_div_start_idle, start, !busy_ff && !fix_ff)
   `SWA_ASSERT_HOLDS(a_div_phase_excl, busy_ff, !fix_ff)
   `SWA_ASSERT_NEXT(a_div_done_pulse, done_ff, !done_ff)

endmodule

// ===== rtl/sliding_window_average_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_average_core
// Sample window of one performance counter with running sum and averages.
// ----------------------------------------------------------------------------
// Keeps the last window_length Q16.16 samples in a circular store with a
// running sum, a fill count and a counter status, and answers one response
// word per request word. A request is taken only while the sequencer is idle;
// a finished response sits in an output register, so the next request can be
// taken while the previous response still waits. Steps per request: a
// sample push goes through accept, store read of the oldest entry, sum update
// and output; "awaiting" and "failure" go through accept and output; a
// whole-window query is paced by the bit-serial divider; a query over the
// newest span samples first walks backward over n = min(fill, span) entries,
// reading one entry per cycle through the single store read port, before the
// divider starts. Writing csr_wr_data sets window_length and empties the
// window (status kept); write it only while the block is idle. No clearing
// pass after reset: a store entry's value is only used after it has been
// written.
// ----------------------------------------------------------------------------
`include "sliding_window_average_core_assert.svh"

module sliding_window_average_core import swa_pkg::*; #(
   parameter int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
   parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   swa_req_if.sink           req_if,
   swa_rsp_if.source         rsp_if,
   input  logic              csr_wr_en,
   input  logic [WLEN_W-1:0] csr_wr_data
);

   localparam int unsigned IDX_W = $clog2(MAX_WINDOW);
   localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int unsigned SUM_W = SAMPLE_BITS + IDX_W;
   localparam int unsigned CMP_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PUSH = 3'd1;  // oldest entry on read port
   localparam logic [2:0] S_SUM  = 3'd2;  // running sum update
   localparam logic [2:0] S_WALK = 3'd3;  // backward walk over the span
   localparam logic [2:0] S_DIV  = 3'd4;  // waiting on the divider
   localparam logic [2:0] S_OUT  = 3'd5;  // hand result to output register

   // control state
   logic [2:0]                   state_ff, state_in;
   logic [WLEN_W-1:0]            wlen_ff, wlen_in;
   logic [IDX_W-1:0]             newest_ff, newest_in;
   logic                         newest_vld_ff, newest_vld_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   status_type                   status_ff, status_in;
   logic                         pend_ff, pend_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // working and payload registers
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [CNT_W-1:0]              remain_ff, remain_in;
   logic [CNT_W-1:0]              n_ff, n_in;
   logic signed [SUM_W-1:0]       acc_ff, acc_in;
   logic signed [SAMPLE_BITS:0]   delta_ff, delta_in;
   logic [AVG_W-1:0]              res_avg_ff, res_avg_in;
   logic                          res_vld_ff, res_vld_in;
   logic [AVG_W-1:0]              rsp_avg_ff, rsp_avg_in;
   logic                          rsp_vres_ff, rsp_vres_in;
   status_type                    rsp_status_ff, rsp_status_in;
   logic [FILL_W-1:0]             rsp_fill_ff, rsp_fill_in;

   // store and divider hookup
   logic                          ram_rd_en;
   logic [IDX_W-1:0]              ram_rd_addr;
   logic                          ram_wr_en;
   logic signed [SAMPLE_BITS-1:0] rd_data;
   logic                          div_start;
   logic signed [SUM_W-1:0]       div_dividend;
   logic [CNT_W-1:0]              div_divisor;
   logic                          div_done;
   logic signed [SUM_W-1:0]       div_quot;

   // derived values
   logic [CNT_W-1:0]            len_eff;
   logic [IDX_W-1:0]            push_idx;
   logic [IDX_W-1:0]            walk_next;
   logic                        query_ok;
   logic [CNT_W-1:0]            span_n;
   logic signed [SAMPLE_BITS:0] samp_x;
   logic signed [SAMPLE_BITS:0] old_x;

   swa_sample_ram #(
      .DEPTH (MAX_WINDOW),
      .WIDTH (SAMPLE_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (sample_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   swa_divider #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // window length clamped to 1..MAX_WINDOW
   always_comb begin
      if (wlen_ff == '0) begin
         len_eff = CNT_W'(1);
      end else if (CMP_W'(wlen_ff) > CMP_W'(MAX_WINDOW)) begin
         len_eff = CNT_W'(MAX_WINDOW);
      end else begin
         len_eff = CNT_W'(wlen_ff);
      end
   end

   // next write slot: wraps at the window length
   assign push_idx = (!newest_vld_ff || (CNT_W'(newest_ff) + CNT_W'(1)) >= len_eff)
                     ? '0 : newest_ff + IDX_W'(1);

   // previous slot, backward walk wraps to the window end
   assign walk_next = (idx_ff != '0) ? idx_ff - IDX_W'(1)
                                     : IDX_W'(len_eff - CNT_W'(1));

   assign query_ok = (status_ff == ST_ACTIVE) &&
                     (CMP_W'(req_if.span) <= CMP_W'(len_eff)) &&
                     (cnt_ff != '0);

   assign span_n = (CMP_W'(cnt_ff) < CMP_W'(req_if.span)) ? cnt_ff
                                                          : CNT_W'(req_if.span);

   assign samp_x = (SAMPLE_BITS + 1)'(sample_ff);
   assign old_x  = (SAMPLE_BITS + 1)'(rd_data);

   always_comb begin
      state_in      = state_ff;
      wlen_in       = wlen_ff;
      newest_in     = newest_ff;
      newest_vld_in = newest_vld_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      status_in     = status_ff;
      pend_in       = pend_ff;
      sample_in     = sample_ff;
      idx_in        = idx_ff;
      remain_in     = remain_ff;
      n_in          = n_ff;
      acc_in        = acc_ff;
      delta_in      = delta_ff;
      res_avg_in    = res_avg_ff;
      res_vld_in    = res_vld_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff;
      ram_wr_en     = 1'b0;
      div_start     = 1'b0;
      div_dividend  = acc_ff;
      div_divisor   = n_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               sample_in  = SAMPLE_BITS'(req_if.sample);
               res_avg_in = '0;
               res_vld_in = 1'b0;
               case (req_if.mode)
                  MODE_SAMPLE: begin
                     // fetch the entry about to be overwritten
                     idx_in      = push_idx;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = push_idx;
                     state_in    = S_PUSH;
                  end
                  MODE_AWAIT: begin
                     status_in = ST_AWAIT;
                     state_in  = S_OUT;
                  end
                  MODE_FAIL: begin
                     status_in     = ST_NOTSUP;
                     cnt_in        = '0;
                     sum_in        = '0;
                     newest_in     = '0;
                     newest_vld_in = 1'b0;
                     state_in      = S_OUT;
                  end
                  MODE_QUERY: begin
                     if (!query_ok) begin
                        state_in = S_OUT;
                     end else if (req_if.span == '0) begin
                        // whole window: running sum over fill
                        div_start    = 1'b1;
                        div_dividend = sum_ff;
                        div_divisor  = cnt_ff;
                        state_in     = S_DIV;
                     end else begin
                        idx_in    = newest_ff;
                        remain_in = span_n;
                        n_in      = span_n;
                        acc_in    = '0;
                        pend_in   = 1'b0;
                        state_in  = S_WALK;
                     end
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_PUSH: begin
            // full window: the oldest sample leaves the sum
            delta_in      = (cnt_ff >= len_eff) ? samp_x - old_x : samp_x;
            ram_wr_en     = 1'b1;
            newest_in     = idx_ff;
            newest_vld_in = 1'b1;
            status_in     = ST_ACTIVE;
            if (cnt_ff < len_eff) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            state_in = S_SUM;
         end
         S_SUM: begin
            sum_in   = sum_ff + SUM_W'(delta_ff);
            state_in = S_OUT;
         end
         S_WALK: begin
            // one read issued per cycle, accumulated in the cycle after
            pend_in = 1'b0;
            if (remain_ff != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff;
               idx_in      = walk_next;
               remain_in   = remain_ff - CNT_W'(1);
               pend_in     = 1'b1;
            end
            if (pend_ff) begin
               acc_in = acc_ff + SUM_W'(rd_data);
            end
            if (remain_ff == '0 && !pend_ff) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               res_avg_in = AVG_W'(div_quot);
               res_vld_in = 1'b1;
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // length write empties the window, status stays
      if (csr_wr_en) begin
         wlen_in       = csr_wr_data;
         cnt_in        = '0;
         sum_in        = '0;
         newest_in     = '0;
         newest_vld_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_avg_in    = rsp_avg_ff;
      rsp_vres_in   = rsp_vres_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_if.ready)) begin
         rsp_valid_in  = 1'b1;
         rsp_avg_in    = res_avg_ff;
         rsp_vres_in   = res_vld_ff;
         rsp_status_in = status_ff;
         rsp_fill_in   = FILL_W'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wlen_ff       <= WLEN_RESET;
         newest_ff     <= '0;
         newest_vld_ff <= 1'b0;
         cnt_ff        <= '0;
         sum_ff        <= '0;
         status_ff     <= ST_INITIAL;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wlen_ff       <= wlen_in;
         newest_ff     <= newest_in;
         newest_vld_ff <= newest_vld_in;
         cnt_ff        <= cnt_in;
         sum_ff        <= sum_in;
         status_ff     <= status_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      idx_ff        <= idx_in;
      remain_ff     <= remain_in;
      n_ff          <= n_in;
      acc_ff        <= acc_in;
      delta_ff      <= delta_in;
      res_avg_ff    <= res_avg_in;
      res_vld_ff    <= res_vld_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_vres_ff   <= rsp_vres_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign req_if.ready     = (state_ff == S_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.average   = rsp_avg_ff;
   assign rsp_if.valid_res = rsp_vres_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.fill      = rsp_fill_ff;

   `SWA_ASSERT_HOLDS(a_fill_in_window, 1'b1, cnt_ff <= len_eff)
   `SWA_ASSERT_HOLDS(a_fill_has_newest, cnt_ff != '0, newest_vld_ff)
   `SWA_ASSERT_NEXT(a_start_enters_div, div_start, state_ff == S_DIV)
   `SWA_ASSERT_HOLDS(a_valid_only_active, rsp_valid_ff && rsp_vres_ff, rsp_status_ff == ST_ACTIVE)

endmodule
